// ===== rtl/srecord_s1_line_parser_assert.svh =====
// Assertion helpers for the S1 line parser.
`ifndef SRECORD_S1_LINE_PARSER_ASSERT_SVH
`define SRECORD_S1_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRS1_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRS1_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srs1_pkg.sv =====
package srs1_pkg;

   localparam int MIN_LINE_CHARS_C = 10;
   localparam int INDEX_BITS_C     = 10;

   localparam logic [7:0] CHAR_S   = 8'h53;
   localparam logic [7:0] CHAR_ONE = 8'h31;

   // error flag bit positions
   localparam int ERR_BITS       = 5;
   localparam int ERR_TYPE_BIT   = 0;
   localparam int ERR_COUNT_BIT  = 1;
   localparam int ERR_ADDR_BIT   = 2;
   localparam int ERR_DATA_BIT   = 3;
   localparam int ERR_CHECK_BIT  = 4;

   localparam logic [7:0] MIN_COUNT = 8'd3;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SHORT = 3'd1,
      ST_TYPE  = 3'd2,
      ST_COUNT = 3'd3,
      ST_ADDR  = 3'd4,
      ST_DATA  = 3'd5,
      ST_CHECK = 3'd6
   } status_type;

   typedef struct packed {
      logic       good;
      logic [3:0] nib;
   } hex_type;

   // decode one ASCII hex digit, either letter case; non-hex gives 0
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.good = 1'b1;
      h.nib  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nib = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         h.nib = c[3:0] + 4'd9;
      end else begin
         h.good = 1'b0;
      end
      return h;
   endfunction

endpackage

// ===== rtl/srecord_s1_line_parser.sv =====
// S1 record line parser: one ASCII character per item, line_end on the last one.
// A data byte or the end-of-line status shows on rsp_ in the cycle after the character
// that completes it is accepted.
// Throughput: one character per cycle; the single output register is the only limit.
// Reset (synchronous, active high) clears all line fields and the output valid.
`include "srecord_s1_line_parser_assert.svh"

module srecord_s1_line_parser #(
   parameter int INDEX_BITS = srs1_pkg::INDEX_BITS_C
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_line_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [15:0] rsp_load_address,
   output logic [7:0]  rsp_byte_offset,
   output logic [7:0]  rsp_byte_value,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_data_size,
   output logic [7:0]  rsp_check_byte
);

   import srs1_pkg::*;

   // one extra bit so lengths and checksum positions never wrap
   localparam int CW = INDEX_BITS + 1;

   // line state
   logic [INDEX_BITS-1:0] char_index_ff, char_index_in;
   logic [3:0]            high_nibble_ff, high_nibble_in;
   logic                  nibble_bad_ff, nibble_bad_in;
   logic [7:0]            record_count_ff, record_count_in;
   logic [15:0]           address_ff, address_in;
   logic [7:0]            checksum_ff, checksum_in;
   logic [ERR_BITS-1:0]   error_ff, error_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff;
   logic [15:0] rsp_addr_ff;
   logic [7:0] rsp_off_ff, rsp_val_ff, rsp_size_ff, rsp_check_ff;
   status_type rsp_status_ff;

   logic       out_free;
   logic       accept;
   hex_type    hx;
   logic [CW-1:0] idx_ext, csum_pos, line_len, data_off_full;
   logic       have_data;
   logic [7:0] data_val;
   logic [7:0] dsize;
   status_type line_status;

   // Take a new item whenever the output slot is empty or drains this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !out_free;
   assign accept    = req_valid && out_free;

   assign hx            = hex_decode(req_char_code);
   assign idx_ext       = CW'(char_index_ff);
   assign csum_pos      = CW'({record_count_ff, 1'b0}) + CW'(2);
   assign line_len      = idx_ext + CW'(1);
   assign data_off_full = idx_ext - CW'(8);

   // Field decode: position in the line selects which field the character feeds.
   always_comb begin
      high_nibble_in  = high_nibble_ff;
      nibble_bad_in   = nibble_bad_ff;
      record_count_in = record_count_ff;
      address_in      = address_ff;
      checksum_in     = checksum_ff;
      error_in        = error_ff;
      have_data       = 1'b0;
      data_val        = {high_nibble_ff, hx.nib};

      priority if (idx_ext == CW'(0)) begin
         if (req_char_code != CHAR_S) error_in[ERR_TYPE_BIT] = 1'b1;
      end else if (idx_ext == CW'(1)) begin
         if (req_char_code != CHAR_ONE) error_in[ERR_TYPE_BIT] = 1'b1;
      end else if (idx_ext == CW'(2)) begin
         high_nibble_in = hx.nib;
         if (!hx.good) error_in[ERR_COUNT_BIT] = 1'b1;
      end else if (idx_ext == CW'(3)) begin
         record_count_in = {high_nibble_ff, hx.nib};
         if (!hx.good) error_in[ERR_COUNT_BIT] = 1'b1;
      end else if (idx_ext < CW'(8)) begin
         address_in = {address_ff[11:0], hx.nib};
         if (!hx.good) error_in[ERR_ADDR_BIT] = 1'b1;
      end else if (record_count_ff >= MIN_COUNT && idx_ext < csum_pos) begin
         // data region: even position holds the high digit, odd completes a byte
         if (!char_index_ff[0]) begin
            high_nibble_in = hx.nib;
            nibble_bad_in  = !hx.good;
         end else begin
            if (!hx.good || nibble_bad_ff) error_in[ERR_DATA_BIT] = 1'b1;
            have_data = 1'b1;
         end
      end else if (record_count_ff >= MIN_COUNT && idx_ext == csum_pos) begin
         high_nibble_in = hx.nib;
         if (!hx.good) error_in[ERR_CHECK_BIT] = 1'b1;
      end else if (record_count_ff >= MIN_COUNT && idx_ext == csum_pos + CW'(1)) begin
         checksum_in = {high_nibble_ff, hx.nib};
         if (!hx.good) error_in[ERR_CHECK_BIT] = 1'b1;
      end else begin
         // past the checksum, or a count below three: drop the character
      end
   end

   assign dsize = (record_count_in >= MIN_COUNT) ? record_count_in - MIN_COUNT : 8'd0;

   // End-of-line status: first failing check wins.
   always_comb begin
      priority if (line_len < CW'(MIN_LINE_CHARS_C)) begin
         line_status = ST_SHORT;
      end else if (error_in[ERR_TYPE_BIT]) begin
         line_status = ST_TYPE;
      end else if (error_in[ERR_COUNT_BIT] || record_count_in < MIN_COUNT ||
                   CW'({record_count_in, 1'b0}) > line_len - CW'(4)) begin
         line_status = ST_COUNT;
      end else if (error_in[ERR_ADDR_BIT]) begin
         line_status = ST_ADDR;
      end else if (error_in[ERR_DATA_BIT]) begin
         line_status = ST_DATA;
      end else if (error_in[ERR_CHECK_BIT]) begin
         line_status = ST_CHECK;
      end else begin
         line_status = ST_OK;
      end
   end

   // Advance the index with saturation; clear it at line end.
   always_comb begin
      if (req_line_end) begin
         char_index_in = '0;
      end else if (char_index_ff != '1) begin
         char_index_in = char_index_ff + INDEX_BITS'(1);
      end else begin
         char_index_in = char_index_ff;
      end
   end

   // Output slot: load on accept, empty once taken, hold while stalled.
   always_comb begin
      if (accept) begin
         rsp_valid_in = req_line_end || have_data;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_index_ff   <= '0;
         high_nibble_ff  <= '0;
         nibble_bad_ff   <= 1'b0;
         record_count_ff <= '0;
         address_ff      <= '0;
         checksum_ff     <= '0;
         error_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            char_index_ff <= char_index_in;
            if (req_line_end) begin
               high_nibble_ff  <= '0;
               nibble_bad_ff   <= 1'b0;
               record_count_ff <= '0;
               address_ff      <= '0;
               checksum_ff     <= '0;
               error_ff        <= '0;
            end else begin
               high_nibble_ff  <= high_nibble_in;
               nibble_bad_ff   <= nibble_bad_in;
               record_count_ff <= record_count_in;
               address_ff      <= address_in;
               checksum_ff     <= checksum_in;
               error_ff        <= error_in;
            end
         end
      end
   end

   // Result payload; a status result wins over a byte completed on the last char.
   always_ff @(posedge clock) begin
      if (accept && (req_line_end || have_data)) begin
         rsp_addr_ff <= address_in;
         rsp_size_ff <= dsize;
         if (req_line_end) begin
            rsp_kind_ff   <= KIND_STATUS;
            rsp_off_ff    <= '0;
            rsp_val_ff    <= '0;
            rsp_status_ff <= line_status;
            rsp_check_ff  <= checksum_in;
         end else begin
            rsp_kind_ff   <= KIND_DATA;
            rsp_off_ff    <= data_off_full[8:1];
            rsp_val_ff    <= data_val;
            rsp_status_ff <= ST_OK;
            rsp_check_ff  <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_load_address = rsp_addr_ff;
   assign rsp_byte_offset  = rsp_off_ff;
   assign rsp_byte_value   = rsp_val_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_data_size    = rsp_size_ff;
   assign rsp_check_byte   = rsp_check_ff;

   // A line end always produces a status result next cycle.
   `SRS1_ASSERT_NEXT(a_end_gives_status, clock, reset, accept && req_line_end,
      rsp_valid_ff && rsp_kind_ff == KIND_STATUS, "line end without status result")
   // A line end restarts the line state.
   `SRS1_ASSERT_NEXT(a_end_clears_line, clock, reset, accept && req_line_end,
      char_index_ff == '0 && error_ff == '0 && record_count_ff == '0,
      "line state not cleared after line end")
   // The index only moves on an accepted character.
   `SRS1_ASSERT_NEXT(a_index_holds, clock, reset, !accept,
      $stable(char_index_ff), "character index moved without an item")
   // Data results carry no status or checksum.
   `SRS1_ASSERT_NOW(a_data_fields, clock, reset, rsp_valid_ff && rsp_kind_ff == KIND_DATA,
      rsp_status_ff == ST_OK && rsp_check_ff == 8'd0, "data result with status fields")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import srs1_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_CHARS  = 2000;
   localparam int LONG_LINE_LEN = 1100;   // well past the saturation point of the index
   localparam int MAX_REPORTS   = 40;

   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_F    = 8'h46;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_F    = 8'h66;

   // One result item as it should appear on the rsp_ ports.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] addr;
      logic [7:0]  off;
      logic [7:0]  val;
      status_type  st;
      logic [7:0]  size;
      logic [7:0]  chk;
   } s1_fields_type;

   // One directed record line. Pinned rows carry a hand-written status item.
   typedef struct {
      string       text;
      bit          pinned;
      status_type  st;
      logic [15:0] addr;
      logic [7:0]  size;
      logic [7:0]  chk;
   } line_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_load_address;
   logic [7:0]  rsp_byte_offset;
   logic [7:0]  rsp_byte_value;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_data_size;
   logic [7:0]  rsp_check_byte;

   srecord_s1_line_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_load_address (rsp_load_address),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_status       (rsp_status),
      .rsp_data_size    (rsp_data_size),
      .rsp_check_byte   (rsp_check_byte)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Parser state mirrored by the predictor; all zero after reset and after each line end.
   logic [INDEX_BITS_C-1:0] scan_pos  = '0;
   logic [3:0]              pend_nib  = '0;
   logic                    pend_bad  = 1'b0;
   logic [7:0]              rec_count = '0;
   logic [15:0]             load_addr = '0;
   logic [7:0]              sum_byte  = '0;
   logic [ERR_BITS-1:0]     err_flags = '0;

   s1_fields_type parsed_fields_q [$];   // items still owed by the parser, oldest first
   logic [7:0]  line_buf [$];          // characters of the line being sent
   line_row_type pin_row;
   bit          pin_active = 1'b0;
   bit          calm_tx = 1'b0;        // sender runs back to back
   bit          calm_rx = 1'b0;        // receiver never stalls
   int unsigned mismatches = 0;
   int unsigned chars_sent = 0;
   int unsigned lines_sent = 0;
   int unsigned data_seen = 0;
   int unsigned status_seen [7];
   int unsigned cycle_count = 0;

   // Directed lines: clean records at the field extremes, then each error in priority
   // order, then the corner cases that are easier left to the predictor.
   line_row_type dir_rows [20] = '{
      '{"S1050000AABBCC",   1'b1, ST_OK,    16'h0000, 8'd2,   8'hCC},
      '{"S104FFFFFFFF",     1'b1, ST_OK,    16'hFFFF, 8'd1,   8'hFF},
      '{"S104abcdefab",     1'b1, ST_OK,    16'hABCD, 8'd1,   8'hAB},
      '{"S103FFFF00",       1'b1, ST_OK,    16'hFFFF, 8'd0,   8'h00},
      '{"S",                1'b1, ST_SHORT, 16'h0000, 8'd0,   8'h00},
      '{"S10400000",        1'b1, ST_SHORT, 16'h0000, 8'd1,   8'h00},
      '{"S9030000FC",       1'b1, ST_TYPE,  16'h0000, 8'd0,   8'hFC},
      '{"X1030000FC",       1'b1, ST_TYPE,  16'h0000, 8'd0,   8'hFC},
      '{"S1000000FC",       1'b1, ST_COUNT, 16'h0000, 8'd0,   8'h00},
      '{"S1020000FC",       1'b1, ST_COUNT, 16'h0000, 8'd0,   8'h00},
      '{"S10A0000FC",       1'b1, ST_COUNT, 16'h0000, 8'd7,   8'h00},
      '{"S1FF0000FC",       1'b1, ST_COUNT, 16'h0000, 8'd252, 8'h00},
      '{"S1G30000FC",       1'b1, ST_COUNT, 16'h0000, 8'd0,   8'hFC},
      '{"S1030G00FC",       1'b1, ST_ADDR,  16'h0000, 8'd0,   8'hFC},
      '{"S1041234ZZ56",     1'b1, ST_DATA,  16'h1234, 8'd1,   8'h56},
      // bad first digit of a data pair only
      '{"S1041234Z156",     1'b0, ST_OK,    16'h0000, 8'd0,   8'h00},
      '{"S1041234AB5?",     1'b1, ST_CHECK, 16'h1234, 8'd1,   8'h50},
      // characters after the checksum are ignored
      '{"S1041234AB56xyz*", 1'b0, ST_OK,    16'h0000, 8'd0,   8'h00},
      // data byte completes on the last character: no data item, only the status
      '{"S1051234ABCD",     1'b0, ST_OK,    16'h0000, 8'd0,   8'h00},
      // every error at once: the type error wins
      '{"X1G3ZZZZ!!",       1'b0, ST_OK,    16'h0000, 8'd0,   8'h00}
   };

   // Advance the mirrored parser by one character; return 1 with the item it produces.
   function automatic bit parse_s1_char(input logic [7:0] c, input logic last,
                                        output s1_fields_type r);
      int unsigned i, cnt, sum_at, len;
      logic [3:0]  nib;
      bit          good, got_byte;
      logic [7:0]  byte_val, byte_off, dsize;
      status_type  st;
      i        = scan_pos;
      cnt      = rec_count;
      sum_at   = 2 + 2 * cnt;
      got_byte = 1'b0;
      byte_val = '0;
      byte_off = '0;
      r        = '0;
      // hex digit in either case; anything else reads as zero and is flagged
      good = 1'b1;
      if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
         nib = 4'(c - DIGIT_ZERO);
      end else if (c >= UPPER_A && c <= UPPER_F) begin
         nib = 4'(c - UPPER_A + 8'd10);
      end else if (c >= LOWER_A && c <= LOWER_F) begin
         nib = 4'(c - LOWER_A + 8'd10);
      end else begin
         nib  = 4'd0;
         good = 1'b0;
      end

      if (i == 0) begin
         if (c != CHAR_S) err_flags[ERR_TYPE_BIT] = 1'b1;
      end else if (i == 1) begin
         if (c != CHAR_ONE) err_flags[ERR_TYPE_BIT] = 1'b1;
      end else if (i == 2) begin
         pend_nib = nib;
         if (!good) err_flags[ERR_COUNT_BIT] = 1'b1;
      end else if (i == 3) begin
         rec_count = {pend_nib, nib};
         if (!good) err_flags[ERR_COUNT_BIT] = 1'b1;
      end else if (i < 8) begin
         load_addr = {load_addr[11:0], nib};
         if (!good) err_flags[ERR_ADDR_BIT] = 1'b1;
      end else if (cnt >= MIN_COUNT && i < sum_at) begin
         if ((i % 2) == 0) begin
            pend_nib = nib;
            pend_bad = !good;
         end else begin
            if (!good || pend_bad) err_flags[ERR_DATA_BIT] = 1'b1;
            byte_val = {pend_nib, nib};
            byte_off = 8'((i - 8) / 2);
            got_byte = 1'b1;
         end
      end else if (cnt >= MIN_COUNT && i == sum_at) begin
         pend_nib = nib;
         if (!good) err_flags[ERR_CHECK_BIT] = 1'b1;
      end else if (cnt >= MIN_COUNT && i == sum_at + 1) begin
         sum_byte = {pend_nib, nib};
         if (!good) err_flags[ERR_CHECK_BIT] = 1'b1;
      end

      cnt   = rec_count;
      dsize = (rec_count >= MIN_COUNT) ? rec_count - MIN_COUNT : 8'd0;

      if (last) begin
         len = i + 1;
         if (len < MIN_LINE_CHARS_C) st = ST_SHORT;
         else if (err_flags[ERR_TYPE_BIT]) st = ST_TYPE;
         else if (err_flags[ERR_COUNT_BIT] || cnt < MIN_COUNT || 2 * cnt > len - 4)
            st = ST_COUNT;
         else if (err_flags[ERR_ADDR_BIT]) st = ST_ADDR;
         else if (err_flags[ERR_DATA_BIT]) st = ST_DATA;
         else if (err_flags[ERR_CHECK_BIT]) st = ST_CHECK;
         else st = ST_OK;
         r.kind = KIND_STATUS;
         r.addr = load_addr;
         r.st   = st;
         r.size = dsize;
         r.chk  = sum_byte;
         // start over for the next line
         scan_pos  = '0;
         pend_nib  = '0;
         pend_bad  = 1'b0;
         rec_count = '0;
         load_addr = '0;
         sum_byte  = '0;
         err_flags = '0;
         return 1'b1;
      end

      if (scan_pos != '1) scan_pos++;
      if (got_byte) begin
         r.kind = KIND_DATA;
         r.addr = load_addr;
         r.off  = byte_off;
         r.val  = byte_val;
         r.st   = ST_OK;
         r.size = dsize;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatches < MAX_REPORTS)
         $display("[%0t] %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // Hex digit with a random letter case.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return DIGIT_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'(v) - 8'd10;
   endfunction

   function automatic void push_hex_byte(input logic [7:0] b);
      line_buf.push_back(hex_char(b[7:4]));
      line_buf.push_back(hex_char(b[3:0]));
   endfunction

   // Send line_buf one character per item, flag the last one, and record what each
   // accepted character should produce.
   task automatic send_line();
      int unsigned k, gap;
      logic        last;
      s1_fields_type r;
      for (k = 0; k < line_buf.size(); k++) begin
         last = (k == line_buf.size() - 1);
         gap  = calm_tx ? 0 : $urandom_range(0, 19);
         if (gap != 0) begin
            // drop valid for the gap; raise it again on a later edge
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_char_code <= line_buf[k];
         req_line_end  <= last;
         do @(posedge clock); while (req_stall !== 1'b0);
         chars_sent++;
         if (parse_s1_char(line_buf[k], last, r)) begin
            if (last && pin_active) begin
               r.st   = pin_row.st;
               r.addr = pin_row.addr;
               r.size = pin_row.size;
               r.chk  = pin_row.chk;
            end
            parsed_fields_q.push_back(r);
         end
      end
      lines_sent++;
   endtask

   // Receiver: hold stall for a random count per item, then take the next item.
   initial begin
      int unsigned hold;
      forever begin
         hold = calm_rx ? 0 : $urandom_range(0, 19);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
      end
   end

   // Checker: every accepted item must match the oldest owed item, field by field.
   always @(posedge clock) begin
      s1_fields_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (parsed_fields_q.size() == 0) begin
            report_mismatch("unowed item, kind", rsp_kind, 0);
         end else begin
            want = parsed_fields_q.pop_front();
            if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_load_address !== want.addr)
               report_mismatch("load_address", rsp_load_address, want.addr);
            if (rsp_byte_offset !== want.off)
               report_mismatch("byte_offset", rsp_byte_offset, want.off);
            if (rsp_byte_value !== want.val)
               report_mismatch("byte_value", rsp_byte_value, want.val);
            if (rsp_status !== want.st) report_mismatch("status", rsp_status, want.st);
            if (rsp_data_size !== want.size)
               report_mismatch("data_size", rsp_data_size, want.size);
            if (rsp_check_byte !== want.chk)
               report_mismatch("check_byte", rsp_check_byte, want.chk);
            if (want.kind == KIND_STATUS) status_seen[want.st]++;
            else data_seen++;
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned k, j, pick, cnt, cut, n_noise, line_no, random_start;
      bit          long_done;
      foreach (status_seen[s]) status_seen[s] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed lines, straight out of reset.
      for (k = 0; k < $size(dir_rows); k++) begin
         pin_row    = dir_rows[k];
         pin_active = dir_rows[k].pinned;
         line_buf.delete();
         for (j = 0; j < dir_rows[k].text.len(); j++) line_buf.push_back(dir_rows[k].text[j]);
         send_line();
      end
      pin_active = 1'b0;

      // Hold the sender until the parser has delivered everything owed.
      req_valid <= 1'b0;
      do @(posedge clock); while (parsed_fields_q.size() != 0);

      // Random lines: mostly well-formed records with random content and random case,
      // some damaged (overwrite, truncate, count below three, inserted character),
      // the rest noise. One very long line saturates the character index.
      random_start = chars_sent;
      long_done    = 1'b0;
      line_no      = 0;
      while (chars_sent < random_start + RANDOM_CHARS) begin
         if (line_no % 16 == 0) begin
            calm_tx = ($urandom_range(0, 3) == 0);
            calm_rx = ($urandom_range(0, 3) == 0);
         end
         line_no++;
         line_buf.delete();
         if (!long_done && chars_sent >= random_start + RANDOM_CHARS / 2) begin
            // full-size record, then junk well past the index limit; run it without gaps
            long_done = 1'b1;
            calm_tx   = 1'b1;
            calm_rx   = 1'b1;
            line_buf.push_back(CHAR_S);
            line_buf.push_back(CHAR_ONE);
            push_hex_byte(8'hFF);
            repeat (255) push_hex_byte(8'($urandom));
            while (line_buf.size() < LONG_LINE_LEN) line_buf.push_back(8'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               cnt = ($urandom_range(0, 24) == 0) ? $urandom_range(15, 255)
                                                  : $urandom_range(3, 14);
               line_buf.push_back(CHAR_S);
               line_buf.push_back(CHAR_ONE);
               push_hex_byte(8'(cnt));
               // the count covers address, data and checksum bytes
               repeat (cnt) push_hex_byte(8'($urandom));
               if ($urandom_range(0, 4) == 0)
                  repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom));
               if (pick >= 60) begin
                  case ($urandom_range(0, 3))
                     0: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom);
                     1: begin
                        cut = $urandom_range(1, line_buf.size() - 1);
                        while (line_buf.size() > cut) void'(line_buf.pop_back());
                     end
                     2: begin
                        line_buf[2] = DIGIT_ZERO;
                        line_buf[3] = hex_char(4'($urandom_range(0, 2)));
                     end
                     default: begin
                        line_buf.insert($urandom_range(0, line_buf.size() - 1), 8'($urandom));
                     end
                  endcase
               end
            end else begin
               n_noise = $urandom_range(1, 24);
               if ($urandom_range(0, 1) == 1) begin
                  line_buf.push_back(CHAR_S);
                  line_buf.push_back(CHAR_ONE);
               end
               while (line_buf.size() < n_noise)
                  line_buf.push_back($urandom_range(0, 1) ? hex_char(4'($urandom))
                                                          : 8'($urandom));
            end
         end
         send_line();
      end

      // Drain: drop valid, wait for every owed item, then a few more edges for strays.
      req_valid <= 1'b0;
      do @(posedge clock); while (parsed_fields_q.size() != 0);
      repeat (8) @(posedge clock);

      $display("Run covered %0d lines, %0d characters: directed records, damaged and",
               lines_sent, chars_sent);
      $display("noise lines, index saturation; %0d data bytes, status ok..checksum %s",
               data_seen,
               $sformatf("%0d %0d %0d %0d %0d %0d %0d", status_seen[0], status_seen[1],
                         status_seen[2], status_seen[3], status_seen[4], status_seen[5],
                         status_seen[6]));
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
